>>> rtl/mvm_pkg.sv
package mvm_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int LEN_W     = 7;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = 38;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN = 1'b1;

  localparam logic REQ_WEIGHT  = 1'b0;
  localparam logic REQ_ELEMENT = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_WAIT,
    ST_DRAIN
  } mvm_state_e;

  typedef struct packed {
    logic rd;
    logic mul;
    logic acc;
    logic clr;
    logic rot;
  } mvm_ctl_t;

endpackage

>>> rtl/matrix_vector_multiply_top.sv
// A weight item or an element item is accepted while the block is in RUN, so items can follow
// back to back up to the final element of a vector.
// That element passes the weight and element registers and the product register into the
// accumulators, and the first row result is registered once control has passed through
// WAIT into DRAIN. The accumulator ring then turns MAX_HEIGHT times, one step a cycle, so
// input is held off through WAIT and the whole turn, and output stalls stretch the turn.
// Reset clears the accumulators and sets both lengths to 64; weights are not reset.
module matrix_vector_multiply_top import mvm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [LEN_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  logic [IDX_W-1:0]        col_index_i,
  input  logic [IDX_W-1:0]        row_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IDX_W-1:0]        out_row_o,
  output logic signed [ACC_W-1:0] out_value_o,
  output logic                    last_row_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;
  localparam int HC = $clog2(MAX_HEIGHT + 1);
  localparam int CW = (HC > LEN_W) ? HC : LEN_W;
  localparam logic [LEN_W-1:0] COL_CAP = LEN_W'((MAX_WIDTH < 64) ? MAX_WIDTH : 64);
  localparam logic [LEN_W-1:0] ROW_CAP = LEN_W'((MAX_HEIGHT < 64) ? MAX_HEIGHT : 64);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_HEIGHT - 1);

  logic [LEN_W-1:0] vec_len_q;
  logic [LEN_W-1:0] out_len_q;
  logic [LEN_W-1:0] vl;
  logic [LEN_W-1:0] ol;

  mvm_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic in_acc;
  logic wr_req;
  logic el_use;
  logic el_emit;
  logic [IW-1:0] col_w;
  logic [AW-1:0] addr;
  logic [CMP_W-1:0] row_c;

  logic v1_q, clr1_q, emit1_q;
  logic v2_q, clr2_q, emit2_q;
  logic signed [VAL_W-1:0] x1_q;

  logic step;
  logic emit_row;

  logic out_valid_q;
  logic [IDX_W-1:0] out_row_q;
  logic [ACC_W-1:0] out_value_q;
  logic last_q;

  mvm_ctl_t ctl;
  logic [ACC_W-1:0] acc [MAX_HEIGHT];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_len_q <= LEN_W'(64);
      out_len_q <= LEN_W'(64);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VEC_LEN: vec_len_q <= cfg_data_i;
        REG_OUT_LEN: out_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    vl = vec_len_q;
    if (vec_len_q == '0) begin
      vl = LEN_W'(1);
    end else if (vec_len_q > COL_CAP) begin
      vl = COL_CAP;
    end
    ol = out_len_q;
    if (out_len_q == '0) begin
      ol = LEN_W'(1);
    end else if (out_len_q > ROW_CAP) begin
      ol = ROW_CAP;
    end
  end

  assign in_acc  = in_valid_i && in_ready_o;
  assign col_w   = IW'(col_index_i);
  assign addr    = col_w[AW-1:0];
  assign row_c   = CMP_W'(row_index_i);
  assign wr_req  = in_acc && (req_type_i == REQ_WEIGHT)
                   && (CMP_W'(col_index_i) < CMP_W'(MAX_WIDTH))
                   && (row_c < CMP_W'(MAX_HEIGHT));
  assign el_use  = in_acc && (req_type_i == REQ_ELEMENT)
                   && (LEN_W'(col_index_i) < vl);
  assign el_emit = el_use && (LEN_W'(col_index_i) == vl - LEN_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      clr1_q  <= 1'b0;
      emit1_q <= 1'b0;
      v2_q    <= 1'b0;
      clr2_q  <= 1'b0;
      emit2_q <= 1'b0;
    end else begin
      v1_q    <= el_use;
      clr1_q  <= el_use && (col_index_i == '0);
      emit1_q <= el_emit;
      v2_q    <= v1_q;
      clr2_q  <= clr1_q;
      emit2_q <= emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (el_use) begin
      x1_q <= value_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_RUN: begin
        if (el_emit) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (emit2_q) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        if (step) begin
          cnt_d = cnt_q + CW'(1);
          if (cnt_q == CNT_LAST) begin
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_RUN);
    emit_row   = (cnt_q < CW'(ol));
    step       = (state_q == ST_DRAIN) && (!emit_row || !out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit_row) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit_row) begin
      out_row_q   <= cnt_q[IDX_W-1:0];
      out_value_q <= acc[0];
      last_q      <= (cnt_q == CW'(ol) - CW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_value_o = out_value_q;
  assign last_row_o  = last_q;

  always_comb begin
    ctl.rd  = el_use;
    ctl.mul = v1_q;
    ctl.acc = v2_q;
    ctl.clr = clr2_q;
    ctl.rot = step;
  end

  for (genvar r = 0; r < MAX_HEIGHT; r++) begin : g_cell
    mvm_cell #(
      .MAX_WIDTH(MAX_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .we_i   (wr_req && (row_c == CMP_W'(r))),
      .addr_i (addr),
      .wdata_i(value_i),
      .x_i    (x1_q),
      .ctl_i  (ctl),
      .nbr_i  (acc[(r + 1) % MAX_HEIGHT]),
      .acc_o  (acc[r])
    );
  end

endmodule

>>> rtl/mvm_cell.sv
module mvm_cell import mvm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [AW-1:0]           addr_i,
  input  logic signed [VAL_W-1:0] wdata_i,
  input  logic signed [VAL_W-1:0] x_i,
  input  mvm_ctl_t                ctl_i,
  input  logic [ACC_W-1:0]        nbr_i,
  output logic [ACC_W-1:0]        acc_o
);

  logic signed [VAL_W-1:0]  mem [MAX_WIDTH];
  logic signed [VAL_W-1:0]  w_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         acc_q;
  logic [ACC_W-1:0]         acc_d;
  logic [ACC_W-1:0]         base;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      w_q <= mem[addr_i];
    end
    if (ctl_i.mul) begin
      prod_q <= w_q * x_i;
    end
  end

  always_comb begin
    base  = ctl_i.clr ? '0 : acc_q;
    acc_d = acc_q;
    if (ctl_i.rot) begin
      acc_d = nbr_i;
    end else if (ctl_i.acc) begin
      acc_d = base + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
